@@ src/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, codes and controller/datapath types of the text console.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int COLUMNS   = 80;
    localparam int ROWS      = 25;
    localparam int CELLS     = COLUMNS * ROWS;
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int CNT_W     = $clog2(CELLS + 1);
    localparam int IDX_W     = 11;
    localparam int ROW_W     = 5;
    localparam int COL_W     = 7;
    localparam int CHAR_W    = 8;
    localparam int ATTR_W    = 8;
    localparam int REQ_W     = 2;

    localparam int TAB_STEP  = 4;
    localparam int TAB_IDX_W = $clog2(TAB_STEP);

    // row = (idx * DIV_RECIP) >> DIV_SHIFT, low by at most one, then corrected
    localparam int DIV_SHIFT = 16;
    localparam int DIV_RECIP = (1 << DIV_SHIFT) / COLUMNS;
    localparam int PROD_W    = IDX_W + DIV_SHIFT;

    localparam logic [REQ_W-1:0] REQ_PUT  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SET  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ = 2'd2;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0A;

    typedef enum logic [2:0] {
        KIND_NOP,
        KIND_PRINT,
        KIND_BS,
        KIND_TAB,
        KIND_NL,
        KIND_SET,
        KIND_READ
    } tcw_kind_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV_MUL,
        OP_DIV_FIX,
        OP_READ_ISSUE,
        OP_READ_TAKE,
        OP_TAB_BLANK,
        OP_SCROLL_START,
        OP_COPY,
        OP_CLEAR,
        OP_APPLY,
        OP_OUT_LOAD
    } tcw_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DIV_FIX,
        ST_READ_TAKE,
        ST_TAB_BLANK,
        ST_SCROLL_START,
        ST_COPY,
        ST_CLEAR,
        ST_APPLY,
        ST_DONE
    } tcw_state_t;

    typedef struct packed {
        tcw_op_t op;
    } tcw_cmd_t;

    typedef struct packed {
        tcw_kind_t kind;
        logic      need_scroll;
        logic      tab_last;
        logic      copy_last;
        logic      clear_last;
        logic      out_free;
    } tcw_status_t;

endpackage

@@ src/tcw_ctrl.sv @@
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer of the text console: walks each transaction through decode,
// tab blanking, scroll copy and clear, cursor update and result hand-off.
// ----------------------------------------------------------------------------
module tcw_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  tcw_pkg::tcw_status_t status,
    output tcw_pkg::tcw_cmd_t    cmd
);

    tcw_pkg::tcw_state_t state_reg;
    tcw_pkg::tcw_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tcw_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = tcw_pkg::OP_NONE;
        in_stall   = (state_reg != tcw_pkg::ST_IDLE);
        unique case (state_reg)
            tcw_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = tcw_pkg::OP_LOAD;
                    state_next = tcw_pkg::ST_DECODE;
                end
            end
            tcw_pkg::ST_DECODE:
            begin
                unique case (status.kind)
                    tcw_pkg::KIND_SET:
                    begin
                        cmd.op     = tcw_pkg::OP_DIV_MUL;
                        state_next = tcw_pkg::ST_DIV_FIX;
                    end
                    tcw_pkg::KIND_READ:
                    begin
                        cmd.op     = tcw_pkg::OP_READ_ISSUE;
                        state_next = tcw_pkg::ST_READ_TAKE;
                    end
                    tcw_pkg::KIND_TAB:
                    begin
                        state_next = tcw_pkg::ST_TAB_BLANK;
                    end
                    tcw_pkg::KIND_PRINT, tcw_pkg::KIND_NL:
                    begin
                        state_next = status.need_scroll ? tcw_pkg::ST_SCROLL_START
                                                        : tcw_pkg::ST_APPLY;
                    end
                    tcw_pkg::KIND_BS:
                    begin
                        state_next = tcw_pkg::ST_APPLY;
                    end
                    default:
                    begin
                        state_next = tcw_pkg::ST_DONE;
                    end
                endcase
            end
            tcw_pkg::ST_DIV_FIX:
            begin
                cmd.op     = tcw_pkg::OP_DIV_FIX;
                state_next = tcw_pkg::ST_DONE;
            end
            tcw_pkg::ST_READ_TAKE:
            begin
                cmd.op     = tcw_pkg::OP_READ_TAKE;
                state_next = tcw_pkg::ST_DONE;
            end
            tcw_pkg::ST_TAB_BLANK:
            begin
                cmd.op = tcw_pkg::OP_TAB_BLANK;
                if (status.tab_last)
                begin
                    state_next = status.need_scroll ? tcw_pkg::ST_SCROLL_START
                                                    : tcw_pkg::ST_APPLY;
                end
            end
            tcw_pkg::ST_SCROLL_START:
            begin
                cmd.op     = tcw_pkg::OP_SCROLL_START;
                state_next = tcw_pkg::ST_COPY;
            end
            tcw_pkg::ST_COPY:
            begin
                cmd.op = tcw_pkg::OP_COPY;
                if (status.copy_last)
                begin
                    state_next = tcw_pkg::ST_CLEAR;
                end
            end
            tcw_pkg::ST_CLEAR:
            begin
                cmd.op = tcw_pkg::OP_CLEAR;
                if (status.clear_last)
                begin
                    state_next = tcw_pkg::ST_APPLY;
                end
            end
            tcw_pkg::ST_APPLY:
            begin
                cmd.op     = tcw_pkg::OP_APPLY;
                state_next = tcw_pkg::ST_DONE;
            end
            tcw_pkg::ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.op     = tcw_pkg::OP_OUT_LOAD;
                    state_next = tcw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tcw_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ src/tcw_datapath.sv @@
// ----------------------------------------------------------------------------
// tcw_datapath
// Screen store (character and attribute memories), cursor, request decode,
// index divider, scroll address counter and the output register.
// ----------------------------------------------------------------------------
module tcw_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tcw_pkg::tcw_cmd_t             cmd,
    output tcw_pkg::tcw_status_t          status,
    input  logic                          cfg_wr_en,
    input  logic [tcw_pkg::ATTR_W-1:0]    cfg_wr_data,
    input  logic [tcw_pkg::REQ_W-1:0]     req_type,
    input  logic [tcw_pkg::CHAR_W-1:0]    char_code,
    input  logic [tcw_pkg::IDX_W-1:0]     cell_index,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [tcw_pkg::ROW_W-1:0]     cursor_row,
    output logic [tcw_pkg::COL_W-1:0]     cursor_col,
    output logic [tcw_pkg::CHAR_W-1:0]    read_char,
    output logic [tcw_pkg::ATTR_W-1:0]    read_attr,
    output logic                          scrolled
);

    localparam int ADDR_W = tcw_pkg::ADDR_W;
    localparam int CNT_W  = tcw_pkg::CNT_W;
    localparam int ROW_W  = tcw_pkg::ROW_W;
    localparam int COL_W  = tcw_pkg::COL_W;
    localparam int CHAR_W = tcw_pkg::CHAR_W;
    localparam int ATTR_W = tcw_pkg::ATTR_W;
    localparam int IDX_W  = tcw_pkg::IDX_W;
    localparam int PROD_W = tcw_pkg::PROD_W;

    logic [CHAR_W-1:0] char_mem [tcw_pkg::CELLS];
    logic [ATTR_W-1:0] attr_mem [tcw_pkg::CELLS];

    // control state
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ATTR_W-1:0] attr_reg;
    logic              pend_reg, pend_next;
    logic              out_valid_reg, out_valid_next;

    // payload
    logic [tcw_pkg::REQ_W-1:0] req_reg, req_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ADDR_W-1:0] dest_reg, dest_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic              scr_reg, scr_next;
    logic [CHAR_W-1:0] rd_char_reg, rd_char_next;
    logic [ATTR_W-1:0] rd_attr_reg, rd_attr_next;
    logic [ROW_W-1:0]  out_row_reg, out_row_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [CHAR_W-1:0] out_char_reg, out_char_next;
    logic [ATTR_W-1:0] out_attr_reg, out_attr_next;
    logic              out_scr_reg, out_scr_next;
    logic [CHAR_W-1:0] char_rdata_reg;
    logic [ATTR_W-1:0] attr_rdata_reg;

    // memory ports
    logic              chr_we, atr_we;
    logic [ADDR_W-1:0] chr_waddr, atr_waddr, rd_addr;
    logic [CHAR_W-1:0] chr_wdata;
    logic [ATTR_W-1:0] atr_wdata;

    // decode
    tcw_pkg::tcw_kind_t kind;
    logic [ADDR_W-1:0] cur_addr;
    logic [ADDR_W-1:0] tab_addr;
    logic [ADDR_W-1:0] q_times_cols;
    logic [ADDR_W-1:0] rem0;
    logic [ROW_W-1:0]  quot0;
    logic [COL_W:0]    col_plus_tab;
    logic              idx_ok;
    logic              at_bottom;
    logic              at_last_col;
    logic              at_last;
    logic              tab_wrap;

    assign cur_addr    = ADDR_W'(row_reg) * ADDR_W'(tcw_pkg::COLUMNS) + ADDR_W'(col_reg);
    assign at_bottom   = (row_reg == ROW_W'(tcw_pkg::ROWS - 1));
    assign at_last_col = (col_reg == COL_W'(tcw_pkg::COLUMNS - 1));
    assign at_last     = at_bottom && at_last_col;
    assign col_plus_tab = {1'b0, col_reg} + (COL_W + 1)'(tcw_pkg::TAB_STEP);
    assign tab_wrap    = (col_plus_tab >= (COL_W + 1)'(tcw_pkg::COLUMNS));
    assign tab_addr    = cur_addr + ADDR_W'(cnt_reg[tcw_pkg::TAB_IDX_W-1:0]);
    assign idx_ok      = (idx_reg < IDX_W'(tcw_pkg::CELLS));
    assign quot0       = prod_reg[tcw_pkg::DIV_SHIFT +: ROW_W];
    assign q_times_cols = ADDR_W'(quot0) * ADDR_W'(tcw_pkg::COLUMNS);
    assign rem0        = ADDR_W'(idx_reg) - q_times_cols;

    always_comb
    begin
        kind = tcw_pkg::KIND_NOP;
        unique case (req_reg)
            tcw_pkg::REQ_PUT:
            begin
                priority if (char_reg == tcw_pkg::CH_NUL)
                    kind = tcw_pkg::KIND_NOP;
                else if (char_reg == tcw_pkg::CH_BS)
                    kind = tcw_pkg::KIND_BS;
                else if (char_reg == tcw_pkg::CH_TAB)
                    kind = tcw_pkg::KIND_TAB;
                else if (char_reg == tcw_pkg::CH_LF || char_reg == tcw_pkg::CH_CR)
                    kind = tcw_pkg::KIND_NL;
                else
                    kind = tcw_pkg::KIND_PRINT;
            end
            tcw_pkg::REQ_SET:
            begin
                kind = idx_ok ? tcw_pkg::KIND_SET : tcw_pkg::KIND_NOP;
            end
            tcw_pkg::REQ_READ:
            begin
                kind = idx_ok ? tcw_pkg::KIND_READ : tcw_pkg::KIND_NOP;
            end
            default:
            begin
                kind = tcw_pkg::KIND_NOP;
            end
        endcase
    end

    always_comb
    begin
        status.kind        = kind;
        unique case (kind)
            tcw_pkg::KIND_PRINT: status.need_scroll = at_last;
            tcw_pkg::KIND_NL:    status.need_scroll = at_bottom;
            tcw_pkg::KIND_TAB:   status.need_scroll = at_bottom && tab_wrap;
            default:             status.need_scroll = 1'b0;
        endcase
        status.tab_last   = (cnt_reg == CNT_W'(tcw_pkg::TAB_STEP - 1));
        status.copy_last  = (cnt_reg == CNT_W'(tcw_pkg::CELLS));
        status.clear_last = (cnt_reg == CNT_W'(tcw_pkg::CELLS - 1));
        status.out_free   = !out_valid_reg || !out_stall;
    end

    always_comb
    begin
        row_next      = row_reg;
        col_next      = col_reg;
        pend_next     = 1'b0;
        req_next      = req_reg;
        char_next     = char_reg;
        idx_next      = idx_reg;
        cnt_next      = cnt_reg;
        dest_next     = dest_reg;
        prod_next     = prod_reg;
        scr_next      = scr_reg;
        rd_char_next  = rd_char_reg;
        rd_attr_next  = rd_attr_reg;
        out_row_next  = out_row_reg;
        out_col_next  = out_col_reg;
        out_char_next = out_char_reg;
        out_attr_next = out_attr_reg;
        out_scr_next  = out_scr_reg;
        out_valid_next = out_valid_reg && out_stall;

        chr_we    = 1'b0;
        atr_we    = 1'b0;
        chr_waddr = cur_addr;
        atr_waddr = cur_addr;
        chr_wdata = char_reg;
        atr_wdata = attr_reg;
        rd_addr   = ADDR_W'(idx_reg);

        // copy writes land in the cycle after their reads
        if (pend_reg)
        begin
            chr_we    = 1'b1;
            atr_we    = 1'b1;
            chr_waddr = dest_reg;
            atr_waddr = dest_reg;
            chr_wdata = char_rdata_reg;
            atr_wdata = attr_rdata_reg;
        end

        unique case (cmd.op)
            tcw_pkg::OP_NONE:
            begin
            end
            tcw_pkg::OP_LOAD:
            begin
                req_next     = req_type;
                char_next    = char_code;
                idx_next     = cell_index;
                cnt_next     = '0;
                scr_next     = 1'b0;
                rd_char_next = '0;
                rd_attr_next = '0;
            end
            tcw_pkg::OP_DIV_MUL:
            begin
                prod_next = PROD_W'(idx_reg) * PROD_W'(tcw_pkg::DIV_RECIP);
            end
            tcw_pkg::OP_DIV_FIX:
            begin
                if (rem0 >= ADDR_W'(tcw_pkg::COLUMNS))
                begin
                    row_next = quot0 + ROW_W'(1);
                    col_next = COL_W'(rem0 - ADDR_W'(tcw_pkg::COLUMNS));
                end
                else
                begin
                    row_next = quot0;
                    col_next = COL_W'(rem0);
                end
            end
            tcw_pkg::OP_READ_ISSUE:
            begin
                rd_addr = ADDR_W'(idx_reg);
            end
            tcw_pkg::OP_READ_TAKE:
            begin
                rd_char_next = char_rdata_reg;
                rd_attr_next = attr_rdata_reg;
            end
            tcw_pkg::OP_TAB_BLANK:
            begin
                chr_we    = (tab_addr < ADDR_W'(tcw_pkg::CELLS));
                chr_waddr = tab_addr;
                chr_wdata = tcw_pkg::CH_BLANK;
                cnt_next  = cnt_reg + CNT_W'(1);
            end
            tcw_pkg::OP_SCROLL_START:
            begin
                cnt_next = CNT_W'(tcw_pkg::COLUMNS);
                scr_next = 1'b1;
            end
            tcw_pkg::OP_COPY:
            begin
                if (cnt_reg != CNT_W'(tcw_pkg::CELLS))
                begin
                    rd_addr   = cnt_reg[ADDR_W-1:0];
                    pend_next = 1'b1;
                    dest_next = cnt_reg[ADDR_W-1:0] - ADDR_W'(tcw_pkg::COLUMNS);
                    cnt_next  = cnt_reg + CNT_W'(1);
                end
                else
                begin
                    cnt_next = CNT_W'(tcw_pkg::CELLS - tcw_pkg::COLUMNS);
                end
            end
            tcw_pkg::OP_CLEAR:
            begin
                chr_we    = 1'b1;
                atr_we    = 1'b1;
                chr_waddr = cnt_reg[ADDR_W-1:0];
                atr_waddr = cnt_reg[ADDR_W-1:0];
                chr_wdata = tcw_pkg::CH_NUL;
                atr_wdata = attr_reg;
                cnt_next  = cnt_reg + CNT_W'(1);
            end
            tcw_pkg::OP_APPLY:
            begin
                unique case (kind)
                    tcw_pkg::KIND_PRINT:
                    begin
                        chr_we    = 1'b1;
                        atr_we    = 1'b1;
                        chr_waddr = at_last ? cur_addr - ADDR_W'(tcw_pkg::COLUMNS) : cur_addr;
                        atr_waddr = chr_waddr;
                        chr_wdata = char_reg;
                        atr_wdata = attr_reg;
                        if (at_last_col)
                        begin
                            col_next = '0;
                            row_next = at_bottom ? row_reg : row_reg + ROW_W'(1);
                        end
                        else
                        begin
                            col_next = col_reg + COL_W'(1);
                        end
                    end
                    tcw_pkg::KIND_BS:
                    begin
                        chr_we    = 1'b1;
                        chr_waddr = (cur_addr == '0) ? cur_addr : cur_addr - ADDR_W'(1);
                        chr_wdata = tcw_pkg::CH_BLANK;
                        if (col_reg != '0)
                        begin
                            col_next = col_reg - COL_W'(1);
                        end
                        else if (row_reg != '0)
                        begin
                            row_next = row_reg - ROW_W'(1);
                            col_next = COL_W'(tcw_pkg::COLUMNS - 1);
                        end
                    end
                    tcw_pkg::KIND_TAB:
                    begin
                        if (tab_wrap)
                        begin
                            col_next = COL_W'(col_plus_tab - (COL_W + 1)'(tcw_pkg::COLUMNS));
                            row_next = at_bottom ? row_reg : row_reg + ROW_W'(1);
                        end
                        else
                        begin
                            col_next = COL_W'(col_plus_tab);
                        end
                    end
                    tcw_pkg::KIND_NL:
                    begin
                        col_next = '0;
                        row_next = at_bottom ? row_reg : row_reg + ROW_W'(1);
                    end
                    default:
                    begin
                    end
                endcase
            end
            tcw_pkg::OP_OUT_LOAD:
            begin
                out_valid_next = 1'b1;
                out_row_next   = row_reg;
                out_col_next   = col_reg;
                out_char_next  = rd_char_reg;
                out_attr_next  = rd_attr_reg;
                out_scr_next   = scr_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= '0;
            col_reg       <= '0;
            attr_reg      <= tcw_pkg::ATTR_RESET;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg       <= row_next;
            col_reg       <= col_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                attr_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        char_reg     <= char_next;
        idx_reg      <= idx_next;
        cnt_reg      <= cnt_next;
        dest_reg     <= dest_next;
        prod_reg     <= prod_next;
        scr_reg      <= scr_next;
        rd_char_reg  <= rd_char_next;
        rd_attr_reg  <= rd_attr_next;
        out_row_reg  <= out_row_next;
        out_col_reg  <= out_col_next;
        out_char_reg <= out_char_next;
        out_attr_reg <= out_attr_next;
        out_scr_reg  <= out_scr_next;
    end

    always_ff @(posedge clk)
    begin
        if (chr_we)
        begin
            char_mem[chr_waddr] <= chr_wdata;
        end
        char_rdata_reg <= char_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (atr_we)
        begin
            attr_mem[atr_waddr] <= atr_wdata;
        end
        attr_rdata_reg <= attr_mem[rd_addr];
    end

    assign out_valid  = out_valid_reg;
    assign cursor_row = out_row_reg;
    assign cursor_col = out_col_reg;
    assign read_char  = out_char_reg;
    assign read_attr  = out_attr_reg;
    assign scrolled   = out_scr_reg;

endmodule

@@ src/text_console_writer.sv @@
// ----------------------------------------------------------------------------
// text_console_writer
// Character-cell text console, 80x25 cells of character and attribute, with
// a cursor; put character, set cursor and read cell transactions.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  -------   ---------------------  ---------------------------------------
//  cfg       cfg_wr_en              cfg_wr_data (text attribute)
//  in        in_valid / in_stall    req_type, char_code, cell_index
//  out       out_valid / out_stall  cursor_row, cursor_col, read_char,
//                                   read_attr, scrolled
//
//  One transaction at a time, sequenced by the controller over one write
//  port per screen memory. A scroll adds a setup step, a copy sweep that
//  moves rows 1 to 24 up by one row and a clear of the bottom row.
//  Reset clears cursor, attribute (0x0A) and control; screen is not cleared.
//  The next transaction is taken while the previous result waits on out_stall.
// ----------------------------------------------------------------------------
module text_console_writer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [tcw_pkg::ATTR_W-1:0]    cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [tcw_pkg::REQ_W-1:0]     req_type,
    input  logic [tcw_pkg::CHAR_W-1:0]    char_code,
    input  logic [tcw_pkg::IDX_W-1:0]     cell_index,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [tcw_pkg::ROW_W-1:0]     cursor_row,
    output logic [tcw_pkg::COL_W-1:0]     cursor_col,
    output logic [tcw_pkg::CHAR_W-1:0]    read_char,
    output logic [tcw_pkg::ATTR_W-1:0]    read_attr,
    output logic                          scrolled
);

    tcw_pkg::tcw_cmd_t    cmd;
    tcw_pkg::tcw_status_t status;

    tcw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    tcw_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_type    (req_type),
        .char_code   (char_code),
        .cell_index  (cell_index),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cursor_row  (cursor_row),
        .cursor_col  (cursor_col),
        .read_char   (read_char),
        .read_attr   (read_attr),
        .scrolled    (scrolled)
    );

endmodule
